// ===== rtl/ptfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfr_pkg
// Shared constants for the page translation block with FIFO frame replacement.
// ----------------------------------------------------------------------------
package ptfr_pkg;

    localparam int VA_BITS     = 20;
    localparam int PA_BITS     = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_BITS   = VA_BITS - OFFSET_BITS;
    localparam int FRAME_BITS  = PA_BITS - OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    localparam int FRAME_COUNT = 1 << FRAME_BITS;
    localparam int CNT_W       = 32;

    localparam int S_TDATA_W   = ((VA_BITS + 7) / 8) * 8;
    localparam int RES_W       = PAGE_BITS + 1 + FRAME_BITS + PA_BITS + 1 + PAGE_BITS
                                 + 3 * CNT_W;
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [CNT_W-1:0]      eviction_count;
        logic [CNT_W-1:0]      fault_count;
        logic [CNT_W-1:0]      translated_count;
        logic [PAGE_BITS-1:0]  victim_page;
        logic                  evicted;
        logic [PA_BITS-1:0]    physical_address;
        logic [FRAME_BITS-1:0] frame_number;
        logic                  hit;
        logic [PAGE_BITS-1:0]  page_number;
    } t_result;

endpackage

// ===== rtl/page_translate_fifo_replace.sv =====
// ----------------------------------------------------------------------------
// page_translate_fifo_replace
// Virtual to physical address translation with FIFO frame replacement.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tdata carries one virtual address.
// Each request yields one result on the master stream, held in an output
// register until taken.
// A request is taken in the idle step, the page table and the frame owner memory
// are read, and the lookup step that follows decides hit or fault, writes the new
// mapping and loads the result. A hit or a fault into a free frame then returns
// to idle; a fault that evicts a page passes through an evict step, as the victim
// page's entry is cleared through the single page table write port.
// The next request is accepted while the previous result still waits; the
// block only holds in its lookup step when the output register is still full.
// After reset the page table is swept clear, one entry per cycle, over all 4096
// entries; no request is accepted during that sweep. All counts saturate.
// When the receiver stalls, the result holds and the block stops after at
// most one further request.
// ----------------------------------------------------------------------------
module page_translate_fifo_replace
    import ptfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tdata: virtual_address[19:0], zero padding above
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: page_number, hit, frame_number, physical_address, evicted,
    // victim_page, translated_count, fault_count, eviction_count, zero padding
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVICT
    } t_state;

    t_state                  r_state;
    logic [PAGE_BITS-1:0]    r_clr_idx;
    logic [PAGE_BITS-1:0]    r_page;
    logic [OFFSET_BITS-1:0]  r_off;
    logic [PAGE_BITS-1:0]    r_victim;
    logic [FRAME_BITS:0]     r_frames_used;
    logic [FRAME_BITS-1:0]   r_ptr;
    logic [CNT_W-1:0]        r_cnt_trans;
    logic [CNT_W-1:0]        r_cnt_fault;
    logic [CNT_W-1:0]        r_cnt_evict;
    logic                    r_out_valid;
    t_result                 r_result;

    logic [FRAME_BITS:0]     r_pm_rd;
    logic [PAGE_BITS-1:0]    r_own_rd;
    logic [FRAME_BITS:0]     page_mem [PAGE_COUNT];
    logic [PAGE_BITS-1:0]    owner_mem [FRAME_COUNT];

    logic                    w_s_acc;
    logic                    w_adv;
    logic                    w_hit;
    logic                    w_full;
    logic [FRAME_BITS-1:0]   w_frame;
    logic [PAGE_BITS-1:0]    w_victim;
    logic [CNT_W-1:0]        n_cnt_trans;
    logic [CNT_W-1:0]        n_cnt_fault;
    logic [CNT_W-1:0]        n_cnt_evict;
    logic                    w_pm_we;
    logic [PAGE_BITS-1:0]    w_pm_wa;
    logic [FRAME_BITS:0]     w_pm_wd;
    logic                    w_own_we;
    t_result                 n_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_adv      = (r_state == S_LOOK) && (!r_out_valid || i_m_tready);

    assign w_hit    = r_pm_rd[FRAME_BITS];
    assign w_full   = r_frames_used[FRAME_BITS];
    assign w_frame  = w_hit  ? r_pm_rd[FRAME_BITS-1:0] :
                      w_full ? r_ptr : r_frames_used[FRAME_BITS-1:0];
    assign w_victim = (!w_hit && w_full) ? r_own_rd : '0;

    assign n_cnt_trans = sat_inc(r_cnt_trans);
    assign n_cnt_fault = w_hit ? r_cnt_fault : sat_inc(r_cnt_fault);
    assign n_cnt_evict = (!w_hit && w_full) ? sat_inc(r_cnt_evict) : r_cnt_evict;

    always_comb begin
        n_result.page_number      = r_page;
        n_result.hit              = w_hit;
        n_result.frame_number     = w_frame;
        n_result.physical_address = {w_frame, r_off};
        n_result.evicted          = !w_hit && w_full;
        n_result.victim_page      = w_victim;
        n_result.translated_count = n_cnt_trans;
        n_result.fault_count      = n_cnt_fault;
        n_result.eviction_count   = n_cnt_evict;
    end

    always_comb begin
        w_pm_we = 1'b0;
        w_pm_wa = r_page;
        w_pm_wd = {1'b1, w_frame};
        unique case (r_state)
            S_CLEAR: begin
                w_pm_we = 1'b1;
                w_pm_wa = r_clr_idx;
                w_pm_wd = '0;
            end
            S_LOOK: begin
                w_pm_we = w_adv && !w_hit;
            end
            S_EVICT: begin
                w_pm_we = 1'b1;
                w_pm_wa = r_victim;
                w_pm_wd = '0;
            end
            default: begin
                w_pm_we = 1'b0;
            end
        endcase
    end

    assign w_own_we = w_adv && !w_hit;

    always_ff @(posedge i_clk) begin
        if (w_pm_we) begin
            page_mem[w_pm_wa] <= w_pm_wd;
        end
        if (w_s_acc) begin
            r_pm_rd <= page_mem[i_s_tdata[VA_BITS-1:OFFSET_BITS]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_own_we) begin
            owner_mem[w_frame] <= r_page;
        end
        if (w_s_acc) begin
            r_own_rd <= owner_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_page <= i_s_tdata[VA_BITS-1:OFFSET_BITS];
            r_off  <= i_s_tdata[OFFSET_BITS-1:0];
        end
        if (w_adv) begin
            r_result <= n_result;
            r_victim <= w_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_frames_used <= '0;
            r_ptr         <= '0;
            r_cnt_trans   <= '0;
            r_cnt_fault   <= '0;
            r_cnt_evict   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == PAGE_BITS'(PAGE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_adv) begin
                        r_cnt_trans <= n_cnt_trans;
                        r_cnt_fault <= n_cnt_fault;
                        r_cnt_evict <= n_cnt_evict;
                        if (!w_hit && !w_full) begin
                            r_frames_used <= r_frames_used + 1'b1;
                        end
                        if (!w_hit && w_full) begin
                            r_ptr   <= r_ptr + 1'b1;
                            r_state <= S_EVICT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EVICT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, r_result};

`ifndef SYNTH
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.hit && r_result.evicted))
        else $error("hit and eviction reported together");

    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_hit && w_full) |=> (r_state == S_EVICT))
        else $error("eviction did not clear the victim entry");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_used <= (FRAME_BITS+1)'(FRAME_COUNT))
        else $error("frame count beyond frame total");

    a_faults_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_fault <= r_cnt_trans) && (r_cnt_evict <= r_cnt_fault))
        else $error("counts out of order");

    a_accept_then_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == S_LOOK))
        else $error("request not followed by lookup");
`endif

endmodule
